// ===== rtl/mwmf_pkg.sv =====
// Shared types and constants for the maze wall map follower.
// Used by maze_wall_map_follower; it depends on nothing else.
package mwmf_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int COORD_W    = 6;
    localparam int SIZE_W     = 7;
    localparam int ADDR_W     = 12;
    localparam int DIR_W      = 3;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [SIZE_W-1:0]  size_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [DIR_W-1:0]   dir_t;
    typedef logic [1:0]         side_t;
    typedef logic [3:0][1:0]    cell_t;

    localparam side_t SIDE_UNKNOWN = 2'd0;
    localparam side_t SIDE_WALL    = 2'd1;
    localparam side_t SIDE_OPEN    = 2'd2;

    localparam dir_t DIR_NORTH = 3'd0;
    localparam dir_t DIR_WEST  = 3'd1;
    localparam dir_t DIR_SOUTH = 3'd2;
    localparam dir_t DIR_EAST  = 3'd3;
    localparam dir_t DIR_NULL  = 3'd4;
    localparam dir_t DIR_FIRST = 3'd5;

    localparam size_t WIDTH_RESET  = 7'd64;
    localparam size_t HEIGHT_RESET = 7'd64;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WR0,
        S_WR1,
        S_RD,
        S_DEC
    } state_t;

    // Saturate a written size into 1..max.
    function automatic size_t clamp_size(input size_t v, input size_t max_v);
        size_t r;
        if (v == '0) begin
            r = size_t'(1);
        end else if (v > max_v) begin
            r = max_v;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/maze_wall_map_follower.sv =====
// Top level of the maze wall map follower: wall map memory, move sequencer
// and right-hand-rule turn advisor. Depends on mwmf_pkg.
//
// The block keeps a map of 64 by 64 cells, one memory word per cell holding
// a two-bit code (unknown, wall, open) for each of the four sides. Each input
// word reports one move attempt; the block marks the walls or openings it
// reveals and returns, in exactly one output word, the direction to try next
// by the right-hand rule together with a status flag. The map lives in a
// single-port synchronous memory with a registered read, so an item passes
// through two write states, a read state and a decision state after it is
// taken, and no new input word is accepted until the last one has reached
// the output register, as that one memory port allows no overlap. The output word sits in a
// register, so the next input word is accepted while a result still waits.
// After reset, and after every write of maze_width or maze_height, a
// clearing pass sweeps all 4096 memory words to unknown; no input word
// is accepted meanwhile, though configuration writes are still taken and
// restart the pass. The pass leaves border sides unknown, but they read
// as wall from the configured size, so a size change needs nothing but the pass.
module maze_wall_map_follower (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_wdata,
    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // old_x[5:0], old_y[11:6], new_x[17:12],
                                   // new_y[23:18], try_dir[26:24], zero fill
    input  logic [0:0]  s_tuser,   // blocked[0]
    // Result words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // next_dir[2:0], zero fill
    output logic [0:0]  m_tuser    // status[0]
);

    // Configuration registers, held already clamped.
    mwmf_pkg::size_t width_reg;
    mwmf_pkg::size_t height_reg;

    // The captured input word.
    mwmf_pkg::coord_t ox_reg, oy_reg, nx_reg, ny_reg;
    mwmf_pkg::dir_t   dir_reg;
    logic             blk_reg;

    mwmf_pkg::state_t state_reg, state_next;
    mwmf_pkg::addr_t  clr_cnt_reg;

    // Result register.
    logic           out_valid_reg;
    mwmf_pkg::dir_t out_dir_reg;
    logic           out_status_reg;

    // Memory port.
    mwmf_pkg::cell_t mem [2**mwmf_pkg::ADDR_W];
    mwmf_pkg::cell_t rd_data_reg;
    mwmf_pkg::addr_t mem_addr;
    logic            mem_we;
    logic [3:0]      mem_lanes;
    mwmf_pkg::side_t mem_code;

    logic in_accept;
    logic out_load;

    assign s_tready  = (state_reg == mwmf_pkg::S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_load  = (state_reg == mwmf_pkg::S_DEC) && (!out_valid_reg || m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_dir_reg};
    assign m_tuser  = out_status_reg;

    // ------------------------------------------------------------------
    // Move classification, all from the captured word.
    // ------------------------------------------------------------------
    logic                 out_of_range;
    logic                 same_pos;
    logic                 is_turn_dir;
    logic [1:0]           d2;
    logic [1:0]           mdir;
    logic                 mdir_ok;
    mwmf_pkg::coord_t     nbx, nby;
    logic                 nb_ok;
    logic                 wall_case, open_case;
    mwmf_pkg::addr_t      addr_a, addr_b;
    logic [3:0]           lanes_a, lanes_b;
    mwmf_pkg::side_t      code_ab;
    logic                 b_write;

    always_comb begin
        out_of_range = ({1'b0, ox_reg} >= width_reg)  || ({1'b0, nx_reg} >= width_reg) ||
                       ({1'b0, oy_reg} >= height_reg) || ({1'b0, ny_reg} >= height_reg);
        same_pos    = (ox_reg == nx_reg) && (oy_reg == ny_reg);
        is_turn_dir = !dir_reg[2];
        d2          = dir_reg[1:0];

        // Direction of a move to an adjacent cell, if it was one.
        mdir    = 2'd0;
        mdir_ok = 1'b1;
        if (ox_reg == nx_reg && ({1'b0, ny_reg} + 7'd1) == {1'b0, oy_reg}) begin
            mdir = mwmf_pkg::DIR_NORTH[1:0];
        end else if (oy_reg == ny_reg && ({1'b0, nx_reg} + 7'd1) == {1'b0, ox_reg}) begin
            mdir = mwmf_pkg::DIR_WEST[1:0];
        end else if (ox_reg == nx_reg && ({1'b0, oy_reg} + 7'd1) == {1'b0, ny_reg}) begin
            mdir = mwmf_pkg::DIR_SOUTH[1:0];
        end else if (oy_reg == ny_reg && ({1'b0, ox_reg} + 7'd1) == {1'b0, nx_reg}) begin
            mdir = mwmf_pkg::DIR_EAST[1:0];
        end else begin
            mdir_ok = 1'b0;
        end

        // Neighbour across the tried side, and whether it lies in the maze.
        nbx   = ox_reg;
        nby   = oy_reg;
        nb_ok = 1'b0;
        case (d2)
            2'd0: begin
                nby   = oy_reg - 6'd1;
                nb_ok = (oy_reg != '0);
            end
            2'd1: begin
                nbx   = ox_reg - 6'd1;
                nb_ok = (ox_reg != '0);
            end
            2'd2: begin
                nby   = oy_reg + 6'd1;
                nb_ok = ({1'b0, oy_reg} + 7'd1) < height_reg;
            end
            default: begin
                nbx   = ox_reg + 6'd1;
                nb_ok = ({1'b0, ox_reg} + 7'd1) < width_reg;
            end
        endcase

        wall_case = !out_of_range && is_turn_dir && same_pos;
        open_case = !out_of_range && is_turn_dir && !same_pos && mdir_ok;

        // First write always goes to the old cell; the second to the
        // neighbour for a bump or to the new cell for a step.
        addr_a  = {oy_reg, ox_reg};
        lanes_a = wall_case ? (4'b0001 << d2) : (4'b0001 << mdir);
        if (wall_case) begin
            addr_b  = {nby, nbx};
            lanes_b = 4'b0001 << (d2 ^ 2'd2);
            code_ab = mwmf_pkg::SIDE_WALL;
        end else begin
            addr_b  = {ny_reg, nx_reg};
            lanes_b = 4'b0001 << (mdir ^ 2'd2);
            code_ab = mwmf_pkg::SIDE_OPEN;
        end
        b_write = (wall_case && nb_ok) || open_case;
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mwmf_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_lanes  = 4'b1111;
        mem_code   = mwmf_pkg::SIDE_UNKNOWN;
        mem_addr   = clr_cnt_reg;
        unique case (state_reg)
            mwmf_pkg::S_CLEAR: begin
                mem_we = 1'b1;
                if (clr_cnt_reg == '1) begin
                    state_next = mwmf_pkg::S_IDLE;
                end
            end
            mwmf_pkg::S_IDLE: begin
                if (in_accept) begin
                    state_next = mwmf_pkg::S_WR0;
                end
            end
            mwmf_pkg::S_WR0: begin
                mem_addr   = addr_a;
                mem_lanes  = lanes_a;
                mem_code   = code_ab;
                mem_we     = wall_case || open_case;
                state_next = mwmf_pkg::S_WR1;
            end
            mwmf_pkg::S_WR1: begin
                mem_addr   = addr_b;
                mem_lanes  = lanes_b;
                mem_code   = code_ab;
                mem_we     = b_write;
                state_next = mwmf_pkg::S_RD;
            end
            mwmf_pkg::S_RD: begin
                // Both writes have landed; the read sees the updated cell.
                mem_addr   = {ny_reg, nx_reg};
                state_next = mwmf_pkg::S_DEC;
            end
            mwmf_pkg::S_DEC: begin
                // Keep reading the same cell so the read data holds while
                // the result register is still full.
                mem_addr = {ny_reg, nx_reg};
                if (out_load) begin
                    state_next = mwmf_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = mwmf_pkg::S_CLEAR;
            end
        endcase
        // A size write restarts the clearing pass.
        if (cfg_we) begin
            state_next = mwmf_pkg::S_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cfg_we) begin
            clr_cnt_reg <= '0;
        end else if (state_reg == mwmf_pkg::S_CLEAR) begin
            clr_cnt_reg <= clr_cnt_reg + mwmf_pkg::addr_t'(1);
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= mwmf_pkg::WIDTH_RESET;
            height_reg <= mwmf_pkg::HEIGHT_RESET;
        end else if (cfg_we) begin
            if (cfg_index == mwmf_pkg::REG_WIDTH) begin
                width_reg <= mwmf_pkg::clamp_size(cfg_wdata,
                                                  mwmf_pkg::size_t'(mwmf_pkg::MAX_WIDTH));
            end else begin
                height_reg <= mwmf_pkg::clamp_size(cfg_wdata,
                                                   mwmf_pkg::size_t'(mwmf_pkg::MAX_HEIGHT));
            end
        end
    end

    // Input capture.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            ox_reg  <= s_tdata[5:0];
            oy_reg  <= s_tdata[11:6];
            nx_reg  <= s_tdata[17:12];
            ny_reg  <= s_tdata[23:18];
            dir_reg <= s_tdata[26:24];
            blk_reg <= s_tuser[0];
        end
    end

    // ------------------------------------------------------------------
    // Wall map memory: one word per cell, one write lane per side.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 4; i++) begin
            if (mem_we && mem_lanes[i]) begin
                mem[mem_addr][i] <= mem_code;
            end
        end
        rd_data_reg <= mem[mem_addr];
    end

    // ------------------------------------------------------------------
    // Turn decision on the updated cell, with the border sides as wall.
    // ------------------------------------------------------------------
    mwmf_pkg::cell_t cell_eff;
    logic [3:0]      pass;
    logic [1:0]      left_d, right_d, back_d, turn_d;
    mwmf_pkg::dir_t  dec_dir;
    logic            dec_status;

    always_comb begin
        cell_eff = rd_data_reg;
        if (ny_reg == '0) begin
            cell_eff[0] = mwmf_pkg::SIDE_WALL;
        end
        if (nx_reg == '0) begin
            cell_eff[1] = mwmf_pkg::SIDE_WALL;
        end
        if (({1'b0, ny_reg} + 7'd1) == height_reg) begin
            cell_eff[2] = mwmf_pkg::SIDE_WALL;
        end
        if (({1'b0, nx_reg} + 7'd1) == width_reg) begin
            cell_eff[3] = mwmf_pkg::SIDE_WALL;
        end
        for (int i = 0; i < 4; i++) begin
            pass[i] = (cell_eff[i] != mwmf_pkg::SIDE_WALL);
        end

        left_d  = d2 + 2'd1;
        right_d = d2 + 2'd3;
        back_d  = d2 ^ 2'd2;
        if (!blk_reg) begin
            if (pass[right_d]) begin
                turn_d = right_d;
            end else if (pass[d2]) begin
                turn_d = d2;
            end else if (pass[left_d]) begin
                turn_d = left_d;
            end else begin
                turn_d = back_d;
            end
        end else begin
            if (pass[left_d]) begin
                turn_d = left_d;
            end else if (pass[back_d]) begin
                turn_d = back_d;
            end else begin
                turn_d = right_d;
            end
        end

        dec_status = 1'b0;
        if (out_of_range) begin
            dec_dir    = mwmf_pkg::DIR_NULL;
            dec_status = 1'b1;
        end else if (dir_reg == mwmf_pkg::DIR_FIRST) begin
            dec_dir = mwmf_pkg::DIR_EAST;
        end else if (!is_turn_dir) begin
            dec_dir = mwmf_pkg::DIR_NULL;
        end else begin
            dec_dir = {1'b0, turn_d};
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_dir_reg    <= dec_dir;
            out_status_reg <= dec_status;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mwmf_pkg::S_CLEAR) |-> !s_tready)
        else $error("input word taken during the clearing pass");

    a_accept_starts_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && !cfg_we) |=> (state_reg == mwmf_pkg::S_WR0))
        else $error("accepted word did not start the write sequence");

    a_error_gives_null: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[2:0] == mwmf_pkg::DIR_NULL))
        else $error("error status without a null move");

    a_write_only_when_owed: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == mwmf_pkg::S_CLEAR || state_reg == mwmf_pkg::S_WR0 ||
                    state_reg == mwmf_pkg::S_WR1))
        else $error("map write outside the write cycles");

    a_oor_leaves_map: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == mwmf_pkg::S_WR0 || state_reg == mwmf_pkg::S_WR1) && out_of_range)
        |-> !mem_we)
        else $error("map written for a position outside the maze");

endmodule

// ===== dv/maze_advice_checker.sv =====
// Checker for the maze wall map follower: keeps its own copy of the wall map,
// predicts the advice for every accepted move word and compares the results.
// Depends on mwmf_pkg for the map, side and direction types.
module maze_advice_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // old_x, old_y, new_x, new_y, try_dir, zero fill
    input  logic [0:0]  s_tuser,   // blocked
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // next_dir, zero fill
    input  logic [0:0]  m_tuser,   // status
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        mwmf_pkg::dir_t next_dir;
        logic           status;
    } advice_t;

    mwmf_pkg::cell_t wall_map [mwmf_pkg::MAX_WIDTH*mwmf_pkg::MAX_HEIGHT];
    int              maze_w;
    int              maze_h;
    advice_t         advice_due [$];

    function automatic int fit_size(input logic [6:0] v, input int max_v);
        if (v == 0) return 1;
        return (v > max_v) ? max_v : int'(v);
    endfunction

    // Everything unknown, with the sides on the configured border walled.
    function automatic void clear_map();
        int x;
        int y;
        for (int i = 0; i < mwmf_pkg::MAX_WIDTH*mwmf_pkg::MAX_HEIGHT; i++) begin
            x = i % mwmf_pkg::MAX_WIDTH;
            y = i / mwmf_pkg::MAX_WIDTH;
            wall_map[i] = '0;
            if (x == 0)          wall_map[i][mwmf_pkg::DIR_WEST]  = mwmf_pkg::SIDE_WALL;
            if (x == maze_w - 1) wall_map[i][mwmf_pkg::DIR_EAST]  = mwmf_pkg::SIDE_WALL;
            if (y == 0)          wall_map[i][mwmf_pkg::DIR_NORTH] = mwmf_pkg::SIDE_WALL;
            if (y == maze_h - 1) wall_map[i][mwmf_pkg::DIR_SOUTH] = mwmf_pkg::SIDE_WALL;
        end
    endfunction

    function automatic void mark(input int x, input int y, input mwmf_pkg::dir_t d,
                                 input mwmf_pkg::side_t code);
        wall_map[y*mwmf_pkg::MAX_WIDTH + x][d[1:0]] = code;
    endfunction

    function automatic logic side_free(input mwmf_pkg::cell_t c, input logic [1:0] k);
        return c[k] != mwmf_pkg::SIDE_WALL;
    endfunction

    // Map update from one move report, then the right-hand-rule advice.
    function automatic advice_t advise_move(input logic [31:0] data, input logic blocked);
        int              ox;
        int              oy;
        int              nx;
        int              ny;
        int              nbx;
        int              nby;
        mwmf_pkg::dir_t  d;
        mwmf_pkg::dir_t  mdir;
        logic [1:0]      ahead;
        logic [1:0]      left;
        logic [1:0]      right;
        logic [1:0]      back;
        logic [1:0]      pick;
        mwmf_pkg::cell_t c;
        advice_t         a;
        ox = int'(data[5:0]);
        oy = int'(data[11:6]);
        nx = int'(data[17:12]);
        ny = int'(data[23:18]);
        d  = data[26:24];
        a.status = 1'b0;
        if (ox >= maze_w || nx >= maze_w || oy >= maze_h || ny >= maze_h) begin
            a.next_dir = mwmf_pkg::DIR_NULL;
            a.status   = 1'b1;
            return a;
        end
        if (d == mwmf_pkg::DIR_FIRST) begin
            a.next_dir = mwmf_pkg::DIR_EAST;
            return a;
        end
        if (d > mwmf_pkg::DIR_EAST) begin
            a.next_dir = mwmf_pkg::DIR_NULL;
            return a;
        end
        ahead = d[1:0];
        if (ox == nx && oy == ny) begin
            mark(ox, oy, d, mwmf_pkg::SIDE_WALL);
            nbx = ox;
            nby = oy;
            case (d)
                mwmf_pkg::DIR_NORTH: nby = oy - 1;
                mwmf_pkg::DIR_WEST:  nbx = ox - 1;
                mwmf_pkg::DIR_SOUTH: nby = oy + 1;
                default:             nbx = ox + 1;
            endcase
            if (nbx >= 0 && nbx < maze_w && nby >= 0 && nby < maze_h)
                mark(nbx, nby, d ^ 3'd2, mwmf_pkg::SIDE_WALL);
        end else begin
            if (ox == nx && ny + 1 == oy)      mdir = mwmf_pkg::DIR_NORTH;
            else if (oy == ny && nx + 1 == ox) mdir = mwmf_pkg::DIR_WEST;
            else if (ox == nx && oy + 1 == ny) mdir = mwmf_pkg::DIR_SOUTH;
            else if (oy == ny && ox + 1 == nx) mdir = mwmf_pkg::DIR_EAST;
            else                               mdir = mwmf_pkg::DIR_NULL;
            if (mdir != mwmf_pkg::DIR_NULL) begin
                mark(ox, oy, mdir, mwmf_pkg::SIDE_OPEN);
                mark(nx, ny, mdir ^ 3'd2, mwmf_pkg::SIDE_OPEN);
            end
        end
        c     = wall_map[ny*mwmf_pkg::MAX_WIDTH + nx];
        left  = ahead + 2'd1;
        right = ahead - 2'd1;
        back  = ahead ^ 2'd2;
        if (!blocked) begin
            if (side_free(c, right))      pick = right;
            else if (side_free(c, ahead)) pick = ahead;
            else if (side_free(c, left))  pick = left;
            else                          pick = back;
        end else begin
            if (side_free(c, left))       pick = left;
            else if (side_free(c, back))  pick = back;
            else                          pick = right;
        end
        a.next_dir = {1'b0, pick};
        return a;
    endfunction

    always @(posedge aclk) begin
        advice_t want;
        if (!aresetn) begin
            maze_w = int'(mwmf_pkg::WIDTH_RESET);
            maze_h = int'(mwmf_pkg::HEIGHT_RESET);
            clear_map();
            advice_due.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == mwmf_pkg::REG_WIDTH)
                    maze_w = fit_size(cfg_wdata, mwmf_pkg::MAX_WIDTH);
                else
                    maze_h = fit_size(cfg_wdata, mwmf_pkg::MAX_HEIGHT);
                clear_map();
            end
            if (s_tvalid && s_tready)
                advice_due.push_back(advise_move(s_tdata, s_tuser[0]));
            if (m_tvalid && m_tready) begin
                if (advice_due.size() == 0) begin
                    $error("result word with no move outstanding: next_dir %0d status %0d",
                           m_tdata[2:0], m_tuser[0]);
                    fail_count++;
                end else begin
                    want = advice_due.pop_front();
                    if (m_tdata[2:0] !== want.next_dir) begin
                        $error("next_dir: expected %0d, got %0d", want.next_dir, m_tdata[2:0]);
                        fail_count++;
                    end
                    if (m_tuser[0] !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser[0]);
                        fail_count++;
                    end
                end
            end
        end
        pending <= advice_due.size();
    end

endmodule

// ===== dv/tb_maze_wall_map_follower.sv =====
// Testbench top for the maze wall map follower: clock, reset, move words,
// size writes and back-pressure, with the verdict at the end of the run.
// Depends on mwmf_pkg, maze_wall_map_follower and maze_advice_checker.
module tb_maze_wall_map_follower;

    // The limit leaves ample room for the slowest correct run: about 475
    // words, stretched by idling and stalls, plus a clearing pass after
    // reset and after each resize.
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        mwmf_pkg::coord_t old_x;
        mwmf_pkg::coord_t old_y;
        mwmf_pkg::coord_t new_x;
        mwmf_pkg::coord_t new_y;
        mwmf_pkg::dir_t   try_dir;
        logic             blocked;
    } move_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = mwmf_pkg::REG_WIDTH;
    logic [6:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;

    int fail_count;
    int pending;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_asks     = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    // The walker's idea of the maze size in use and of the avatar position.
    int maze_cols = 64;
    int maze_rows = 64;
    int px        = 0;
    int py        = 0;

    always #5 aclk = ~aclk;

    maze_wall_map_follower i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    maze_advice_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Result side. A hold-off request from the stimulus makes the receiver
    // refuse every word for a long stretch, counted here, so that the output
    // register fills and the block has to push back on its input. Otherwise
    // it stalls at random at the rate the current phase asks for.
    always @(posedge aclk) begin
        if (hold_asks != hold_served) begin
            hold_served <= hold_asks;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic move_t make_move(input int ox, input int oy, input int nx, input int ny,
                                        input mwmf_pkg::dir_t d, input logic b);
        move_t m;
        m.old_x   = mwmf_pkg::coord_t'(ox);
        m.old_y   = mwmf_pkg::coord_t'(oy);
        m.new_x   = mwmf_pkg::coord_t'(nx);
        m.new_y   = mwmf_pkg::coord_t'(ny);
        m.try_dir = d;
        m.blocked = b;
        return m;
    endfunction

    // Offer one move word and return at the edge that takes it. Valid is left
    // high on return, so back-to-back words never drop it within one step;
    // the next call lowers it only when it decides to idle.
    task automatic offer(input move_t m);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, m.try_dir, m.new_y, m.new_x, m.old_y, m.old_x};
        s_tuser  <= m.blocked;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [6:0] v);
        int eff;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        eff = (v == 0) ? 1 : ((v > 64) ? 64 : int'(v));
        if (idx == mwmf_pkg::REG_WIDTH) maze_cols = eff;
        else                            maze_rows = eff;
    endtask

    // Resizing is only done with the block idle: drained, then waited out
    // further to cover its internal latency, then both sizes written.
    task automatic resize(input logic [6:0] w, input logic [6:0] h);
        drain();
        repeat (8) @(posedge aclk);
        write_reg(mwmf_pkg::REG_WIDTH, w);
        write_reg(mwmf_pkg::REG_HEIGHT, h);
        px = 0;
        py = 0;
    endtask

    // One random move word. Most are honest reports of a walk through the
    // configured maze, so walls and openings build up around revisited cells;
    // the rest are reports whose blocked flag lies, null, first and undefined
    // directions, jumps to cells that are not adjacent, and raw noise that
    // mostly falls outside the configured maze.
    task automatic random_move(output move_t m);
        int             r;
        int             tx;
        int             ty;
        mwmf_pkg::dir_t d;
        logic           in_maze;
        r  = $urandom_range(99);
        d  = mwmf_pkg::dir_t'($urandom_range(3));
        tx = px;
        ty = py;
        case (d)
            mwmf_pkg::DIR_NORTH: ty = py - 1;
            mwmf_pkg::DIR_WEST:  tx = px - 1;
            mwmf_pkg::DIR_SOUTH: ty = py + 1;
            default:             tx = px + 1;
        endcase
        in_maze = (tx >= 0 && tx < maze_cols && ty >= 0 && ty < maze_rows);
        if (r < 65) begin
            if (!in_maze || $urandom_range(99) < 35) begin
                m = make_move(px, py, px, py, d, 1'b1);
            end else begin
                m  = make_move(px, py, tx, ty, d, 1'b0);
                px = tx;
                py = ty;
            end
        end else if (r < 72) begin
            if (in_maze) begin
                m  = make_move(px, py, tx, ty, d, 1'b1);
                px = tx;
                py = ty;
            end else begin
                m = make_move(px, py, px, py, d, 1'b0);
            end
        end else if (r < 79) begin
            m = make_move(px, py, px, py, mwmf_pkg::dir_t'($urandom_range(7, 4)),
                          1'($urandom_range(1)));
        end else if (r < 87) begin
            tx = $urandom_range(maze_cols - 1);
            ty = $urandom_range(maze_rows - 1);
            m  = make_move(px, py, tx, ty, mwmf_pkg::dir_t'($urandom_range(7)),
                           1'($urandom_range(1)));
            px = tx;
            py = ty;
        end else begin
            m = make_move($urandom_range(63), $urandom_range(63), $urandom_range(63),
                          $urandom_range(63), mwmf_pkg::dir_t'($urandom_range(7)),
                          1'($urandom_range(1)));
        end
    endtask

    task automatic run_phase(input int n, input int idle_s, input int idle_m);
        move_t m;
        send_idle_pct = idle_s;
        stall_pct    <= idle_m;
        repeat (n) begin
            random_move(m);
            offer(m);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words on the reset size of 64 by 64. The first word also
        // waits out the clearing pass that follows reset.
        offer(make_move(0, 0, 0, 0, mwmf_pkg::DIR_FIRST, 1'b0));
        offer(make_move(0, 0, 0, 0, mwmf_pkg::DIR_NORTH, 1'b1));   // into the north border
        offer(make_move(0, 0, 1, 0, mwmf_pkg::DIR_EAST, 1'b0));
        offer(make_move(1, 0, 1, 0, mwmf_pkg::DIR_NULL, 1'b0));
        offer(make_move(1, 0, 1, 0, mwmf_pkg::dir_t'(6), 1'b1));   // undefined directions
        offer(make_move(1, 0, 1, 0, mwmf_pkg::dir_t'(7), 1'b0));
        offer(make_move(63, 63, 63, 63, mwmf_pkg::DIR_EAST, 1'b1)); // far corner
        offer(make_move(63, 63, 63, 63, mwmf_pkg::DIR_SOUTH, 1'b1));
        offer(make_move(63, 62, 63, 63, mwmf_pkg::DIR_SOUTH, 1'b0));
        offer(make_move(63, 63, 62, 63, mwmf_pkg::DIR_WEST, 1'b0));
        offer(make_move(62, 63, 10, 20, mwmf_pkg::DIR_NORTH, 1'b0)); // jump, nothing marked
        // The blocked flag disagreeing with the positions, both ways round.
        offer(make_move(10, 20, 10, 20, mwmf_pkg::DIR_WEST, 1'b0));
        offer(make_move(10, 20, 10, 19, mwmf_pkg::DIR_NORTH, 1'b1));
        offer(make_move(10, 19, 10, 19, mwmf_pkg::DIR_SOUTH, 1'b1));
        // A move whose reported direction is not the one actually taken.
        offer(make_move(20, 20, 20, 21, mwmf_pkg::DIR_EAST, 1'b0));

        // Directed words on a 5 by 4 maze: positions outside it, border
        // sides whose neighbour lies outside, and a cell walled on all sides.
        resize(7'd5, 7'd4);
        offer(make_move(4, 3, 4, 3, mwmf_pkg::DIR_EAST, 1'b1));
        offer(make_move(4, 3, 4, 3, mwmf_pkg::DIR_SOUTH, 1'b1));
        offer(make_move(5, 0, 4, 0, mwmf_pkg::DIR_WEST, 1'b0));
        offer(make_move(0, 4, 0, 3, mwmf_pkg::DIR_NORTH, 1'b0));
        offer(make_move(0, 0, 5, 0, mwmf_pkg::DIR_FIRST, 1'b0));
        offer(make_move(63, 63, 63, 63, mwmf_pkg::DIR_NULL, 1'b0));
        offer(make_move(3, 2, 4, 2, mwmf_pkg::DIR_EAST, 1'b0));
        offer(make_move(4, 2, 4, 2, mwmf_pkg::DIR_NORTH, 1'b1));
        offer(make_move(4, 2, 4, 2, mwmf_pkg::DIR_WEST, 1'b1));
        offer(make_move(4, 2, 4, 2, mwmf_pkg::DIR_SOUTH, 1'b1));
        offer(make_move(4, 2, 4, 2, mwmf_pkg::DIR_EAST, 1'b0));

        // Random phases over a range of sizes, including a width of zero and
        // sizes above the maximum, with idling patterns that vary between phases.
        resize(7'd4, 7'd4);
        run_phase(70, 0, 0);
        resize(7'd0, 7'd127);
        run_phase(50, 45, 0);

        // Long receiver hold-off while the sender keeps offering words.
        resize(7'd8, 7'd3);
        hold_asks <= hold_asks + 1;
        run_phase(70, 0, 45);

        resize(7'd64, 7'd64);
        run_phase(80, 32, 32);
        resize(7'd127, 7'd0);
        run_phase(50, 0, 0);

        // Mid-phase the sender pauses until every result is back.
        resize(7'd6, 7'd7);
        run_phase(40, 32, 32);
        drain();
        run_phase(40, 32, 32);

        resize(7'd1, 7'd2);
        run_phase(50, 45, 0);

        drain();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mwmf_pkg.sv
rtl/maze_wall_map_follower.sv
dv/maze_advice_checker.sv
dv/tb_maze_wall_map_follower.sv
